// File: hdl/pod_pkg.sv
package pod_pkg;

   // default sizes
   localparam int ANGLE_BITS_DEF = 16;
   localparam int POS_BITS_DEF   = 32;

   // action codes
   localparam logic [1:0] ACT_SET   = 2'd0;
   localparam logic [1:0] ACT_DIFF  = 2'd1;
   localparam logic [1:0] ACT_BIKE  = 2'd2;
   localparam logic [1:0] ACT_FIXED = 2'd3;

   // register indexes
   localparam logic [1:0] REG_INV_LENGTH = 2'd0;
   localparam logic [1:0] REG_TIME_STEP  = 2'd1;
   localparam logic [1:0] REG_MAX_TURN   = 2'd2;
   localparam logic [1:0] REG_CRUISE     = 2'd3;

   // register reset values
   localparam logic [23:0] INV_LENGTH_RST = 24'd65536;
   localparam logic [15:0] TIME_STEP_RST  = 16'd655;
   localparam logic [14:0] MAX_TURN_RST   = 15'd4096;
   localparam logic [15:0] CRUISE_RST     = 16'd256;
   localparam int          POS_RST        = 65536;

   // CORDIC datapath
   localparam int XY_W         = 34;
   localparam int CORDIC_ITERS = 30;
   localparam int IT_W         = $clog2(CORDIC_ITERS);
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
   };

   // tangent divider
   localparam int MAG_W     = XY_W - 1;
   localparam int DIV_NUM_W = MAG_W + 16;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam logic [31:0] TAN_LIMIT = 32'h7FFF_FFFF;

   // 1/(2 pi) in Q0.32
   localparam logic signed [32:0] INV_TWO_PI_Q32 = 33'sd683565276;

endpackage

// File: hdl/pod_cordic.sv
module pod_cordic (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [31:0]                     angle,
   output logic                            done,
   output logic signed [pod_pkg::XY_W-1:0] cos_out,
   output logic signed [pod_pkg::XY_W-1:0] sin_out
);
   import pod_pkg::*;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [IT_W-1:0]        it_ff, it_in;
   logic                   busy_ff, busy_in, flip_ff, flip_in, done_ff, done_in;
   logic [31:0]            a_rot, a_eff;
   logic signed [XY_W-1:0] xs, ys, at;

   // one rotation step per cycle
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      a_rot   = angle + 32'h4000_0000;
      a_eff   = a_rot[31] ? angle + 32'h8000_0000 : angle;
      xs      = x_ff >>> it_ff;
      ys      = y_ff >>> it_ff;
      at      = XY_W'(ATAN_TURNS[it_ff]);
      if (start) begin
         // fold the angle into the right half plane
         flip_in = a_rot[31];
         z_in    = XY_W'($signed(a_eff));
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         it_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[XY_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         it_in = it_ff + 1'b1;
         if (it_ff == IT_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         flip_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         flip_ff <= flip_in;
         it_ff   <= it_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// File: hdl/pod_div.sv
module pod_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [pod_pkg::XY_W-1:0] sin_in,
   input  logic signed [pod_pkg::XY_W-1:0] cos_in,
   output logic                            done,
   output logic signed [31:0]              tan_out
);
   import pod_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [MAG_W:0]       rem_ff, rem_in;
   logic [MAG_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic                 sneg_ff, sneg_in, cneg_ff, cneg_in;
   logic [XY_W-1:0]      smag, cmag;
   logic [MAG_W:0]       shifted;
   logic [MAG_W+1:0]     trial;
   logic                 ge;
   logic [31:0]          mag;
   logic                 neg;

   // restoring division of |sin|*2^16 by |cos|, one quotient bit a cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sneg_in = sneg_ff;
      cneg_in = cneg_ff;
      done_in = 1'b0;
      smag    = sin_in[XY_W-1] ? XY_W'(-sin_in) : XY_W'(sin_in);
      cmag    = cos_in[XY_W-1] ? XY_W'(-cos_in) : XY_W'(cos_in);
      shifted = {rem_ff[MAG_W-1:0], num_ff[DIV_NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      ge      = !trial[MAG_W+1];
      if (start) begin
         num_in  = {smag[MAG_W-1:0], 16'b0};
         den_in  = cmag[MAG_W-1:0];
         rem_in  = '0;
         cnt_in  = '0;
         sneg_in = sin_in[XY_W-1];
         cneg_in = cos_in[XY_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial[MAG_W:0] : shifted;
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // saturate, then apply the sign (zero cosine takes the sine's sign)
   always_comb begin
      if (den_ff == '0 || num_ff > DIV_NUM_W'(TAN_LIMIT)) begin
         mag = TAN_LIMIT;
      end else begin
         mag = num_ff[31:0];
      end
      neg     = (den_ff == '0) ? sneg_ff : (sneg_ff ^ cneg_ff);
      tan_out = neg ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      sneg_ff <= sneg_in;
      cneg_ff <= cneg_in;
   end

   assign done = done_ff;

endmodule

// File: hdl/pose_odometry_integrator.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    action, wheel speeds, speed, steer, pose
// rsp_      out        rsp_valid/rsp_ready    pose and held turn rate after the item
// csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Set pose goes straight to the result step; the other actions are paced by the 30-step
// CORDIC (run once, twice for bicycle), the 49-step tangent divider and the shared
// 33x33 multiplier, whose steps are the states MUL_HI, MUL_LO and MUL_ACC.
// A finished item waits in the rsp_ register; a stall there holds the sequencer.
// Synchronous reset returns pose to (1 m, 1 m, 0) and registers to defaults.
module pose_odometry_integrator #(
   parameter int ANGLE_BITS = pod_pkg::ANGLE_BITS_DEF,
   parameter int POS_BITS   = pod_pkg::POS_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_left_speed,
   input  logic signed [15:0] req_right_speed,
   input  logic signed [15:0] req_speed,
   input  logic signed [15:0] req_steer_rate,
   input  logic signed [31:0] req_set_x,
   input  logic signed [31:0] req_set_y,
   input  logic signed [15:0] req_set_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [15:0] rsp_out_heading,
   output logic signed [15:0] rsp_out_turn_rate,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import pod_pkg::*;

   localparam int DX_W   = 40;
   localparam int SUM_W  = ((POS_BITS > DX_W) ? POS_BITS : DX_W) + 1;
   localparam int HD_SH  = 32 - ANGLE_BITS;
   localparam logic [31:0] HD_HALF = 32'd1 << (HD_SH - 1);
   localparam int LOAD_SH = 24 - ANGLE_BITS;

   // sequencer states
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_MV_0    = 5'd1;
   localparam logic [4:0] S_MV_1    = 5'd2;
   localparam logic [4:0] S_MV_2    = 5'd3;
   localparam logic [4:0] S_MV_3    = 5'd4;
   localparam logic [4:0] S_MV_4    = 5'd5;
   localparam logic [4:0] S_MV_5    = 5'd6;
   localparam logic [4:0] S_T1_0    = 5'd7;
   localparam logic [4:0] S_T1_1    = 5'd8;
   localparam logic [4:0] S_T1_2    = 5'd9;
   localparam logic [4:0] S_T2_0    = 5'd10;
   localparam logic [4:0] S_T2_1    = 5'd11;
   localparam logic [4:0] S_T2_2    = 5'd12;
   localparam logic [4:0] S_T2_3    = 5'd13;
   localparam logic [4:0] S_T2_4    = 5'd14;
   localparam logic [4:0] S_T2_5    = 5'd15;
   localparam logic [4:0] S_T2_6    = 5'd16;
   localparam logic [4:0] S_A3_0    = 5'd17;
   localparam logic [4:0] S_A3_1    = 5'd18;
   localparam logic [4:0] S_A3_2    = 5'd19;
   localparam logic [4:0] S_A3_3    = 5'd20;
   localparam logic [4:0] S_HD      = 5'd21;
   localparam logic [4:0] S_CWAIT   = 5'd22;
   localparam logic [4:0] S_DWAIT   = 5'd23;
   localparam logic [4:0] S_MUL_HI  = 5'd24;
   localparam logic [4:0] S_MUL_LO  = 5'd25;
   localparam logic [4:0] S_MUL_ACC = 5'd26;
   localparam logic [4:0] S_FIN     = 5'd27;

   // saturate to the position width
   function automatic logic [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      if (&v[SUM_W-1:POS_BITS-1] || ~|v[SUM_W-1:POS_BITS-1]) begin
         return v[POS_BITS-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(POS_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_BITS-1){1'b1}}};
      end
   endfunction

   // saturate to 32 bits for the result item
   function automatic logic [31:0] sat_32(input logic signed [SUM_W-1:0] v);
      if (&v[SUM_W-1:31] || ~|v[SUM_W-1:31]) begin
         return v[31:0];
      end else if (v[SUM_W-1]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   logic [4:0]               state_ff, state_in, ret_ff, ret_in;
   logic [1:0]               act_ff, act_in;
   logic signed [16:0]       vel_ff, vel_in, diff_ff, diff_in;
   logic signed [15:0]       w_ff, w_in;
   logic signed [63:0]       ma_ff, ma_in, acc_ff, acc_in;
   logic signed [32:0]       mb_ff, mb_in;
   logic signed [65:0]       prod_ff, prod_in;
   logic signed [DX_W-1:0]   dx_ff, dx_in;
   logic signed [POS_BITS-1:0] east_ff, east_in, north_ff, north_in;
   logic [ANGLE_BITS-1:0]    heading_ff, heading_in;
   logic signed [15:0]       held_ff, held_in;
   logic [23:0]              inv_ff;
   logic [15:0]              ts_ff;
   logic [14:0]              maxw_ff;
   logic signed [15:0]       cruise_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [15:0]       rsp_h_ff, rsp_h_in, rsp_w_ff, rsp_w_in;

   logic                     cs_start, cs_done, dv_start, dv_done;
   logic [31:0]              cs_angle;
   logic signed [XY_W-1:0]   cs_cos, cs_sin;
   logic signed [31:0]       dv_tan;
   logic signed [32:0]       mul_a;
   logic signed [16:0]       steer17, maxw17;
   logic signed [15:0]       w_clamp;
   logic signed [63:0]       rnd24, rnd25;
   logic signed [DX_W-1:0]   dnew;
   logic [31:0]              dsum;
   logic [23:0]              hload;
   logic [ANGLE_BITS+15:0]   hwide;

   pod_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cs_start),
      .angle   (cs_angle),
      .done    (cs_done),
      .cos_out (cs_cos),
      .sin_out (cs_sin)
   );

   pod_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (dv_start),
      .sin_in  (cs_sin),
      .cos_in  (cs_cos),
      .done    (dv_done),
      .tan_out (dv_tan)
   );

   // shared multiplier: high half then low half of the 64-bit operand
   assign mul_a = (state_ff == S_MUL_HI) ? 33'(ma_ff[63:32]) : {1'b0, ma_ff[31:0]};
   assign prod_in = mul_a * mb_ff;

   // steer clamp
   always_comb begin
      steer17 = 17'(req_steer_rate);
      maxw17  = $signed({2'b00, maxw_ff});
      if (steer17 > maxw17) begin
         w_clamp = maxw17[15:0];
      end else if (steer17 < -maxw17) begin
         w_clamp = 16'(-maxw17);
      end else begin
         w_clamp = req_steer_rate;
      end
   end

   // move rounding, heading rounding, heading width conversion
   assign rnd24 = (acc_ff + 64'sd8388608) >>> 24;
   assign rnd25 = (acc_ff + 64'sd16777216) >>> 25;
   assign dnew  = (act_ff == ACT_DIFF) ? rnd25[DX_W-1:0] : rnd24[DX_W-1:0];
   assign dsum  = acc_ff[63:32] + HD_HALF;
   assign hload = {req_set_heading, 8'b0} >> LOAD_SH;
   assign hwide = {heading_ff, 16'b0} >> ANGLE_BITS;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      act_in       = act_ff;
      vel_in       = vel_ff;
      diff_in      = diff_ff;
      w_in         = w_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      acc_in       = acc_ff;
      dx_in        = dx_ff;
      east_in      = east_ff;
      north_in     = north_ff;
      heading_in   = heading_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_w_in     = rsp_w_ff;
      cs_start     = 1'b0;
      cs_angle     = {heading_ff, {HD_SH{1'b0}}};
      dv_start     = 1'b0;
      req_ready    = (state_ff == S_IDLE);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in  = req_action;
               w_in    = w_clamp;
               diff_in = 17'(req_right_speed) - 17'(req_left_speed);
               unique case (req_action)
                  ACT_SET: begin
                     east_in    = sat_pos(SUM_W'(req_set_x));
                     north_in   = sat_pos(SUM_W'(req_set_y));
                     heading_in = hload[ANGLE_BITS-1:0];
                     held_in    = '0;
                     state_in   = S_FIN;
                  end
                  ACT_DIFF: begin
                     vel_in   = 17'(req_left_speed) + 17'(req_right_speed);
                     state_in = S_MV_0;
                  end
                  ACT_BIKE: begin
                     vel_in   = 17'(req_speed);
                     held_in  = w_clamp;
                     state_in = S_MV_0;
                  end
                  ACT_FIXED: begin
                     vel_in   = 17'(cruise_ff);
                     state_in = S_A3_0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // move along the current heading
         S_MV_0: begin
            cs_start = 1'b1;
            ret_in   = S_MV_1;
            state_in = S_CWAIT;
         end
         S_MV_1: begin
            ma_in = 64'(vel_ff); mb_in = 33'(cs_cos);
            ret_in = S_MV_2; state_in = S_MUL_HI;
         end
         S_MV_2: begin
            ma_in = acc_ff >>> 14; mb_in = 33'(ts_ff);
            ret_in = S_MV_3; state_in = S_MUL_HI;
         end
         S_MV_3: begin
            dx_in = dnew;
            ma_in = 64'(vel_ff); mb_in = 33'(cs_sin);
            ret_in = S_MV_4; state_in = S_MUL_HI;
         end
         S_MV_4: begin
            ma_in = acc_ff >>> 14; mb_in = 33'(ts_ff);
            ret_in = S_MV_5; state_in = S_MUL_HI;
         end
         S_MV_5: begin
            east_in  = sat_pos(SUM_W'(east_ff) + SUM_W'(dx_ff));
            north_in = sat_pos(SUM_W'(north_ff) + SUM_W'(dnew));
            if (act_ff == ACT_DIFF) begin
               state_in = S_T1_0;
            end else if (act_ff == ACT_BIKE) begin
               state_in = S_T2_0;
            end else begin
               state_in = S_FIN;
            end
         end
         // differential drive turn
         S_T1_0: begin
            ma_in = 64'(diff_ff); mb_in = 33'(inv_ff);
            ret_in = S_T1_1; state_in = S_MUL_HI;
         end
         S_T1_1: begin
            ma_in = acc_ff; mb_in = 33'(ts_ff);
            ret_in = S_T1_2; state_in = S_MUL_HI;
         end
         S_T1_2: begin
            ma_in = acc_ff >>> 8; mb_in = INV_TWO_PI_Q32;
            ret_in = S_HD; state_in = S_MUL_HI;
         end
         // bicycle turn: tan of the steer rate, then scale
         S_T2_0: begin
            ma_in = 64'(w_ff) <<< 20; mb_in = INV_TWO_PI_Q32;
            ret_in = S_T2_1; state_in = S_MUL_HI;
         end
         S_T2_1: begin
            cs_start = 1'b1;
            cs_angle = acc_ff[63:32];
            ret_in   = S_T2_2;
            state_in = S_CWAIT;
         end
         S_T2_2: begin
            dv_start = 1'b1;
            state_in = S_DWAIT;
         end
         S_T2_3: begin
            ma_in = 64'(vel_ff); mb_in = 33'(dv_tan);
            ret_in = S_T2_4; state_in = S_MUL_HI;
         end
         S_T2_4: begin
            ma_in = acc_ff >>> 8; mb_in = 33'(inv_ff);
            ret_in = S_T2_5; state_in = S_MUL_HI;
         end
         S_T2_5: begin
            ma_in = acc_ff >>> 16; mb_in = 33'(ts_ff);
            ret_in = S_T2_6; state_in = S_MUL_HI;
         end
         S_T2_6: begin
            ma_in = acc_ff; mb_in = INV_TWO_PI_Q32;
            ret_in = S_HD; state_in = S_MUL_HI;
         end
         // fixed speed turn, then move
         S_A3_0: begin
            ma_in = 64'(vel_ff); mb_in = 33'(w_ff);
            ret_in = S_A3_1; state_in = S_MUL_HI;
         end
         S_A3_1: begin
            ma_in = acc_ff; mb_in = 33'(inv_ff);
            ret_in = S_A3_2; state_in = S_MUL_HI;
         end
         S_A3_2: begin
            ma_in = acc_ff >>> 20; mb_in = 33'(ts_ff);
            ret_in = S_A3_3; state_in = S_MUL_HI;
         end
         S_A3_3: begin
            ma_in = acc_ff; mb_in = INV_TWO_PI_Q32;
            ret_in = S_HD; state_in = S_MUL_HI;
         end
         // add the rounded turn to the heading
         S_HD: begin
            heading_in = heading_ff + dsum[31:HD_SH];
            state_in   = (act_ff == ACT_FIXED) ? S_MV_0 : S_FIN;
         end
         S_CWAIT: begin
            if (cs_done) begin
               state_in = ret_ff;
            end
         end
         S_DWAIT: begin
            if (dv_done) begin
               state_in = S_T2_3;
            end
         end
         S_MUL_HI: begin
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            acc_in   = {prod_ff[31:0], 32'b0};
            state_in = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            acc_in   = acc_ff + prod_ff[63:0];
            state_in = ret_ff;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = sat_32(SUM_W'(east_ff));
               rsp_y_in     = sat_32(SUM_W'(north_ff));
               rsp_h_in     = hwide[15:0];
               rsp_w_in     = held_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         east_ff      <= POS_BITS'(POS_RST);
         north_ff     <= POS_BITS'(POS_RST);
         heading_ff   <= '0;
         held_ff      <= '0;
         inv_ff       <= INV_LENGTH_RST;
         ts_ff        <= TIME_STEP_RST;
         maxw_ff      <= MAX_TURN_RST;
         cruise_ff    <= CRUISE_RST;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         east_ff      <= east_in;
         north_ff     <= north_in;
         heading_ff   <= heading_in;
         held_ff      <= held_in;
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               REG_INV_LENGTH: inv_ff    <= csr_wdata;
               REG_TIME_STEP:  ts_ff     <= csr_wdata[15:0];
               REG_MAX_TURN:   maxw_ff   <= csr_wdata[14:0];
               REG_CRUISE:     cruise_ff <= csr_wdata[15:0];
               default:        inv_ff    <= inv_ff;
            endcase
         end
      end
      act_ff   <= act_in;
      vel_ff   <= vel_in;
      diff_ff  <= diff_in;
      w_ff     <= w_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dx_ff    <= dx_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_h_ff <= rsp_h_in;
      rsp_w_ff <= rsp_w_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_heading   = rsp_h_ff;
   assign rsp_out_turn_rate = rsp_w_ff;

   // a pose load goes straight to the result stage
   a_set_fin: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_SET) |=> (state_ff == S_FIN))
      else $error("pose load did not finish directly");

   // multiply subroutine returns where it was called from
   a_mul_ret: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_ACC) |=> (state_ff == $past(ret_ff)))
      else $error("multiply returned to wrong step");

   // a held result blocks the finish step
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FIN))
      else $error("finish overran a held result");

   // no new item while busy
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("ready while busy");

endmodule
